>>> hdl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

  // Command codes carried by req_type.
  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_RDACK  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_SNDACK = 3'd5
  } cmd_t;

  localparam int HALF_W = 16;
  localparam logic [HALF_W-1:0] HALF_RESET = 16'd250;

  // Last phase index of each sequence.
  localparam logic [4:0] PH_LAST_BYTE  = 5'd23;
  localparam logic [4:0] PH_LAST_START = 5'd3;
  localparam logic [4:0] PH_LAST_SHORT = 5'd2;

  // Decoupling queue between the front and the engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified tick as it travels through the queue.
  typedef struct packed {
    logic       cmd_ok;      // a legal command is requested on this tick
    cmd_t       cmd;         // decoded command, meaningful when cmd_ok
    logic [7:0] init_shift;  // preloaded transmit shift value
    logic       sda_in;      // SDA level seen on this tick
  } q_entry_t;

endpackage

>>> hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: front end, queue and line engine.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_stall    cmd_valid, req_type, tx_byte, tx_ack, sda_in
//   output    out_valid / out_stall  scl_out, sda_out, busy_res, done_res,
//                                    rx_byte, ack_received
//   config    cfg_valid / cfg_ready  cfg_data (half_period_ticks)
//
// One request (one bus tick) is taken per cycle while in_stall is low and yields
// exactly one result. A request passes through the two-entry queue and then
// the engine's result register. The engine's state update sets the rate.
// Reset (rst, synchronous) releases both lines, clears busy and sets the half
// period to 250 ticks. A stalled output holds its result; the queue absorbs up
// to two further requests, and in_stall rises only when the queue is full.
module i2c_master_bit_engine
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Input channel.
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd_valid,
  input  logic [2:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic              tx_ack,
  input  logic              sda_in,
  // Output channel.
  output logic              out_valid,
  input  logic              out_stall,
  output logic              scl_out,
  output logic              sda_out,
  output logic              busy_res,
  output logic              done_res,
  output logic [7:0]        rx_byte,
  output logic              ack_received,
  // Configuration write channel.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_data
);

  q_entry_t front_entry;
  q_entry_t q_head;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     q_push;

  // Half period always writable; writes must come while idle, not enforced.
  assign cfg_ready = 1'b1;

  // A request enters the queue whenever there is room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  i2cm_front u_front (
    .cmd_valid (cmd_valid),
    .req_type  (req_type),
    .tx_byte   (tx_byte),
    .tx_ack    (tx_ack),
    .sda_in    (sda_in),
    .entry     (front_entry)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // The engine consumes one queued tick whenever its result register is
  // empty or being drained this cycle.
  i2cm_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_out      (scl_out),
    .sda_out      (sda_out),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .rx_byte      (rx_byte),
    .ack_received (ack_received)
  );

`ifndef SYNTHESIS
  // A finishing tick always leaves the engine idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("done and busy reported together");

  // A sequence cannot finish on two delivered ticks in a row.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && done_res) |=> !(out_valid && done_res))
    else $error("done reported on consecutive results");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

>>> hdl/i2cm_front.sv
// Front end: classifies one input tick into a queue entry.
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic       cmd_valid,
  input  logic [2:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       tx_ack,
  input  logic       sda_in,
  output q_entry_t   entry
);

  always_comb begin
    entry.cmd_ok     = 1'b0;
    entry.cmd        = CMD_START;
    entry.init_shift = 8'h00;
    entry.sda_in     = sda_in;
    case (req_type)
      CMD_START: begin
        entry.cmd_ok = cmd_valid;
        entry.cmd    = CMD_START;
      end
      CMD_STOP: begin
        entry.cmd_ok = cmd_valid;
        entry.cmd    = CMD_STOP;
      end
      CMD_WRITE: begin
        entry.cmd_ok     = cmd_valid;
        entry.cmd        = CMD_WRITE;
        entry.init_shift = tx_byte;
      end
      CMD_RDACK: begin
        entry.cmd_ok = cmd_valid;
        entry.cmd    = CMD_RDACK;
      end
      CMD_READ: begin
        entry.cmd_ok = cmd_valid;
        entry.cmd    = CMD_READ;
      end
      CMD_SNDACK: begin
        // The acknowledge level goes out through the MSB of the shifter.
        entry.cmd_ok     = cmd_valid;
        entry.cmd        = CMD_SNDACK;
        entry.init_shift = {tx_ack, 7'b0};
      end
      default: begin
        entry.cmd_ok = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/i2cm_queue.sv
// Short FIFO that decouples the front end from the line engine.
module i2cm_queue
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/i2cm_engine.sv
// Line engine: steps the SCL/SDA phase sequences and registers each result.
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [HALF_W-1:0] cfg_data,
  input  logic              q_not_empty,
  input  q_entry_t          q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              scl_out,
  output logic              sda_out,
  output logic              busy_res,
  output logic              done_res,
  output logic [7:0]        rx_byte,
  output logic              ack_received
);

  logic [HALF_W-1:0] half_period;
  logic              scl_level, scl_level_next;
  logic              sda_level, sda_level_next;
  logic              busy, busy_next;
  cmd_t              cmd, cmd_next;
  logic [4:0]        phase, phase_next;
  logic [1:0]        sub, sub_next;
  logic [HALF_W-1:0] tick, tick_next;
  logic [7:0]        tx_shift, tx_shift_next;
  logic [7:0]        rx_shift, rx_shift_next;
  logic              ack_seen, ack_seen_next;
  logic              done_next;
  logic              apply;
  logic [4:0]        last_phase;

  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_comb begin
    case (cmd)
      CMD_WRITE, CMD_READ: last_phase = PH_LAST_BYTE;
      CMD_START:           last_phase = PH_LAST_START;
      default:             last_phase = PH_LAST_SHORT;
    endcase
  end

  always_comb begin
    scl_level_next = scl_level;
    sda_level_next = sda_level;
    busy_next      = busy;
    cmd_next       = cmd;
    phase_next     = phase;
    sub_next       = sub;
    tick_next      = tick;
    tx_shift_next  = tx_shift;
    rx_shift_next  = rx_shift;
    ack_seen_next  = ack_seen;
    done_next      = 1'b0;
    apply          = 1'b0;

    if (!busy) begin
      if (q_head.cmd_ok) begin
        cmd_next = q_head.cmd;
        if (q_head.cmd == CMD_WRITE || q_head.cmd == CMD_SNDACK) begin
          tx_shift_next = q_head.init_shift;
        end
        if (q_head.cmd == CMD_READ) begin
          rx_shift_next = 8'h00;
        end
        phase_next = 5'd0;
        sub_next   = 2'd0;
        busy_next  = 1'b1;
        tick_next  = HALF_W'(1);
        apply      = 1'b1;
      end
    end else if (tick >= half_period) begin
      if (phase >= last_phase) begin
        busy_next = 1'b0;
        done_next = 1'b1;
      end else begin
        phase_next = phase + 5'd1;
        sub_next   = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
        tick_next  = HALF_W'(1);
        apply      = 1'b1;
      end
    end else begin
      tick_next = tick + HALF_W'(1);
    end

    // Line change at the start of the new phase.
    if (apply) begin
      case (cmd_next)
        CMD_START: begin
          case (phase_next)
            5'd0:    scl_level_next = 1'b1;
            5'd1:    sda_level_next = 1'b1;
            5'd2:    sda_level_next = 1'b0;
            default: scl_level_next = 1'b0;
          endcase
        end
        CMD_STOP: begin
          case (phase_next)
            5'd0:    sda_level_next = 1'b0;
            5'd1:    scl_level_next = 1'b1;
            default: sda_level_next = 1'b1;
          endcase
        end
        CMD_WRITE, CMD_SNDACK: begin
          case (sub_next)
            2'd0: sda_level_next = tx_shift_next[7];
            2'd1: scl_level_next = 1'b1;
            default: begin
              scl_level_next = 1'b0;
              tx_shift_next  = {tx_shift_next[6:0], 1'b0};
            end
          endcase
        end
        CMD_RDACK, CMD_READ: begin
          case (sub_next)
            2'd0: sda_level_next = 1'b1;
            2'd1: scl_level_next = 1'b1;
            default: begin
              if (cmd_next == CMD_RDACK) begin
                ack_seen_next = q_head.sda_in;
              end else begin
                rx_shift_next = {rx_shift_next[6:0], q_head.sda_in};
              end
              scl_level_next = 1'b0;
            end
          endcase
        end
        default: begin
          scl_level_next = scl_level;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      busy        <= 1'b0;
      cmd         <= CMD_START;
      phase       <= '0;
      sub         <= '0;
      tick        <= '0;
      tx_shift    <= '0;
      rx_shift    <= '0;
      ack_seen    <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        half_period <= cfg_data;
      end
      if (q_pop) begin
        scl_level <= scl_level_next;
        sda_level <= sda_level_next;
        busy      <= busy_next;
        cmd       <= cmd_next;
        phase     <= phase_next;
        sub       <= sub_next;
        tick      <= tick_next;
        tx_shift  <= tx_shift_next;
        rx_shift  <= rx_shift_next;
        ack_seen  <= ack_seen_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; loaded only when a tick is taken from the queue.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      scl_out      <= scl_level_next;
      sda_out      <= sda_level_next;
      busy_res     <= busy_next;
      done_res     <= done_next;
      rx_byte      <= rx_shift_next;
      ack_received <= ack_seen_next;
    end
  end

endmodule

>>> tb/sv/i2c_master_bit_engine_tb.sv
// Self-checking testbench for the I2C master bit engine: one request per bus tick.
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  // One bus tick as it is offered on the input channel.
  typedef struct {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       tx_ack;
    logic       sda_in;
  } bus_tick_t;

  // Line levels and status the engine reports for one tick.
  typedef struct {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack;
  } line_state_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              cmd_valid;
  logic [2:0]        req_type;
  logic [7:0]        tx_byte;
  logic              tx_ack;
  logic              sda_in;
  logic              out_valid;
  logic              out_stall;
  logic              scl_out;
  logic              sda_out;
  logic              busy_res;
  logic              done_res;
  logic [7:0]        rx_byte;
  logic              ack_received;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [HALF_W-1:0] cfg_data;

  i2c_master_bit_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd_valid    (cmd_valid),
    .req_type     (req_type),
    .tx_byte      (tx_byte),
    .tx_ack       (tx_ack),
    .sda_in       (sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .scl_out      (scl_out),
    .sda_out      (sda_out),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .rx_byte      (rx_byte),
    .ack_received (ack_received),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Requests waiting to be driven, and line states still owed by the engine.
  bus_tick_t   pending_ticks[$];
  line_state_t pending_levels[$];
  bus_tick_t   cur_tick;
  bit          tick_held;
  int          ticks_queued;
  int          snd_idle_pct;
  int          rcv_stall_pct;
  int          error_count;

  // Shadow copy of the engine: half period, line levels and sequencer state.
  logic [15:0] bus_half;
  logic        bus_scl;
  logic        bus_sda;
  logic        bus_busy;
  cmd_t        bus_cmd;
  logic [4:0]  bus_phase;
  logic [15:0] bus_count;
  logic [7:0]  bus_tx;
  logic [7:0]  bus_rx;
  logic        bus_ack;

  function automatic logic [4:0] last_phase(cmd_t c);
    if (c == CMD_WRITE || c == CMD_READ) return PH_LAST_BYTE;
    if (c == CMD_START) return PH_LAST_START;
    return PH_LAST_SHORT;
  endfunction

  // Each phase changes one line; data commands repeat a three-phase bit cell
  // (set SDA, raise SCL, lower SCL), and reads sample SDA as SCL falls.
  function automatic void apply_phase(logic [4:0] p, logic sdain);
    logic [4:0] sub;
    sub = 5'(p % 3);
    case (bus_cmd)
      CMD_START: begin
        if (p == 0) bus_scl = 1'b1;
        else if (p == 1) bus_sda = 1'b1;
        else if (p == 2) bus_sda = 1'b0;
        else bus_scl = 1'b0;
      end
      CMD_STOP: begin
        if (p == 0) bus_sda = 1'b0;
        else if (p == 1) bus_scl = 1'b1;
        else bus_sda = 1'b1;
      end
      CMD_WRITE, CMD_SNDACK: begin
        if (sub == 0) bus_sda = bus_tx[7];
        else if (sub == 1) bus_scl = 1'b1;
        else begin
          bus_scl = 1'b0;
          bus_tx = {bus_tx[6:0], 1'b0};
        end
      end
      CMD_RDACK, CMD_READ: begin
        if (sub == 0) bus_sda = 1'b1;
        else if (sub == 1) bus_scl = 1'b1;
        else begin
          if (bus_cmd == CMD_RDACK) bus_ack = sdain;
          else bus_rx = {bus_rx[6:0], sdain};
          bus_scl = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // Advances the shadow engine by one accepted tick and records the levels
  // the engine must report for it.
  function automatic void advance_bus_tick(bus_tick_t t);
    line_state_t r;
    logic        fin;
    fin = 1'b0;
    if (!bus_busy) begin
      // Only a legal command on an idle tick starts a sequence.
      if (t.cmd_valid && t.req_type <= CMD_SNDACK) begin
        bus_cmd = cmd_t'(t.req_type);
        if (bus_cmd == CMD_WRITE) bus_tx = t.tx_byte;
        else if (bus_cmd == CMD_SNDACK) bus_tx = t.tx_ack ? 8'h80 : 8'h00;
        else if (bus_cmd == CMD_READ) bus_rx = 8'h00;
        bus_phase = 5'd0;
        bus_busy = 1'b1;
        apply_phase(5'd0, t.sda_in);
        bus_count = 16'd1;
      end
    end else if (bus_count >= bus_half) begin
      // A zero half period passes this test on every tick, like a period of one.
      if (bus_phase >= last_phase(bus_cmd)) begin
        bus_busy = 1'b0;
        fin = 1'b1;
      end else begin
        bus_phase = bus_phase + 5'd1;
        apply_phase(bus_phase, t.sda_in);
        bus_count = 16'd1;
      end
    end else begin
      bus_count = bus_count + 16'd1;
    end
    r.scl  = bus_scl;
    r.sda  = bus_sda;
    r.busy = bus_busy;
    r.done = fin;
    r.rx   = bus_rx;
    r.ack  = bus_ack;
    pending_levels.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Driver: a request stays on the bus until it is taken, and a new one is
  // picked at the falling edge only once the previous one has been accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!tick_held) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          cur_tick = pending_ticks.pop_front();
          tick_held = 1'b1;
          in_valid  <= 1'b1;
          cmd_valid <= cur_tick.cmd_valid;
          req_type  <= cur_tick.req_type;
          tx_byte   <= cur_tick.tx_byte;
          tx_ack    <= cur_tick.tx_ack;
          sda_in    <= cur_tick.sda_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // Monitor: both handshakes are sampled at the rising edge. An accepted
  // request feeds the shadow engine; an accepted result is checked against
  // the oldest outstanding prediction.
  always @(posedge clk) begin
    line_state_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        advance_bus_tick(cur_tick);
        tick_held = 1'b0;
      end
      if (out_valid && !out_stall) begin
        if (pending_levels.size() == 0) begin
          report_mismatch("result with no request outstanding", rx_byte, 8'h00);
        end else begin
          want = pending_levels.pop_front();
          if (scl_out !== want.scl)
            report_mismatch("scl_out", 8'(scl_out), 8'(want.scl));
          if (sda_out !== want.sda)
            report_mismatch("sda_out", 8'(sda_out), 8'(want.sda));
          if (busy_res !== want.busy)
            report_mismatch("busy_res", 8'(busy_res), 8'(want.busy));
          if (done_res !== want.done)
            report_mismatch("done_res", 8'(done_res), 8'(want.done));
          if (rx_byte !== want.rx)
            report_mismatch("rx_byte", rx_byte, want.rx);
          if (ack_received !== want.ack)
            report_mismatch("ack_received", 8'(ack_received), 8'(want.ack));
        end
      end
    end
  end

  function automatic void enqueue(bus_tick_t t);
    pending_ticks.push_back(t);
    ticks_queued++;
  endfunction

  function automatic void queue_idle(int n);
    bus_tick_t t;
    for (int i = 0; i < n; i++) begin
      t.cmd_valid = 1'b0;
      t.req_type  = 3'($urandom_range(7));
      t.tx_byte   = 8'($urandom);
      t.tx_ack    = 1'($urandom);
      t.sda_in    = 1'($urandom);
      enqueue(t);
    end
  endfunction

  // Queues a lone command followed by n idle ticks, for sequences that are
  // too long to be run to completion.
  function automatic void queue_lone(logic [2:0] req, int n);
    bus_tick_t t;
    t.cmd_valid = 1'b1;
    t.req_type  = req;
    t.tx_byte   = 8'($urandom);
    t.tx_ack    = 1'($urandom);
    t.sda_in    = 1'($urandom);
    enqueue(t);
    queue_idle(n);
  endfunction

  // Queues a command and the ticks that its sequence occupies. While the
  // sequence runs, SDA follows sda_pat bit by bit so that reads see a chosen
  // byte; noise_pct of those ticks carry a command that must be ignored,
  // and the finishing tick often carries one too.
  function automatic void queue_command(logic [2:0] req, logic [7:0] txb, logic txa,
                                        logic [7:0] sda_pat, int noise_pct);
    bus_tick_t t;
    int        hh;
    int        span;
    int        bitpos;
    hh = (bus_half == 0) ? 1 : int'(bus_half);
    span = (req <= CMD_SNDACK) ? (int'(last_phase(cmd_t'(req))) + 1) * hh : 0;
    t.cmd_valid = 1'b1;
    t.req_type  = req;
    t.tx_byte   = txb;
    t.tx_ack    = txa;
    t.sda_in    = sda_pat[7];
    enqueue(t);
    for (int i = 1; i <= span; i++) begin
      t.cmd_valid = ($urandom_range(99) < noise_pct) ||
                    (i == span && $urandom_range(3) == 0);
      t.req_type  = 3'($urandom_range(7));
      t.tx_byte   = 8'($urandom);
      t.tx_ack    = 1'($urandom);
      bitpos      = (i / hh) / 3;
      t.sda_in    = (bitpos < 8) ? sda_pat[7 - bitpos] : 1'($urandom);
      enqueue(t);
    end
  endfunction

  function automatic void random_traffic(int budget);
    int stop_at;
    int pick;
    stop_at = ticks_queued + budget;
    while (ticks_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80)
        queue_command(3'($urandom_range(5)), 8'($urandom), 1'($urandom),
                      8'($urandom), 10);
      else if (pick < 88)
        queue_command(3'($urandom_range(7, 6)), 8'($urandom), 1'($urandom),
                      8'($urandom), 0);
      else
        queue_idle($urandom_range(1, 4));
      // Half of the commands follow the previous sequence back to back.
      if ($urandom_range(1) == 1) queue_idle($urandom_range(1, 3));
    end
  endfunction

  // Waits until every request has been taken and answered, then lets the
  // engine's pipeline run dry.
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || tick_held || pending_levels.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_half(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    bus_half = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    cmd_valid = 1'b0;
    req_type  = CMD_START;
    tx_byte   = 8'h00;
    tx_ack    = 1'b0;
    sda_in    = 1'b1;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    tick_held = 1'b0;
    ticks_queued = 0;
    error_count  = 0;
    snd_idle_pct  = 10;
    rcv_stall_pct = 79;
    bus_half  = HALF_RESET;
    bus_scl   = 1'b1;
    bus_sda   = 1'b1;
    bus_busy  = 1'b0;
    bus_cmd   = CMD_START;
    bus_phase = 5'd0;
    bus_count = 16'd0;
    bus_tx    = 8'h00;
    bus_rx    = 8'h00;
    bus_ack   = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset half period: a start sequence runs far enough for its second
    // phase to begin 250 ticks in; the rest of it finishes at the short
    // period written next.
    queue_lone(CMD_START, 260);
    wait_idle();

    // Directed pass at one tick per phase: unknown codes, every command,
    // byte extremes, both acknowledge levels, and commands sent while busy.
    write_half(16'd1);
    queue_idle(4);
    queue_command(3'd6, 8'hFF, 1'b1, 8'h00, 0);
    queue_command(3'd7, 8'h00, 1'b0, 8'hFF, 0);
    queue_command(CMD_START, 8'h00, 1'b0, 8'h00, 50);
    queue_command(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 0);
    queue_command(CMD_WRITE, 8'h00, 1'b1, 8'hFF, 50);
    queue_command(CMD_WRITE, 8'hA5, 1'b0, 8'h3C, 0);
    queue_command(CMD_RDACK, 8'h00, 1'b0, 8'h00, 0);
    queue_command(CMD_RDACK, 8'h00, 1'b0, 8'hFF, 0);
    queue_command(CMD_READ, 8'h00, 1'b0, 8'hFF, 0);
    queue_command(CMD_READ, 8'h00, 1'b0, 8'h00, 30);
    queue_command(CMD_READ, 8'h00, 1'b0, 8'h5A, 0);
    queue_command(CMD_SNDACK, 8'h00, 1'b0, 8'hFF, 0);
    queue_command(CMD_SNDACK, 8'h00, 1'b1, 8'h00, 0);
    queue_command(CMD_STOP, 8'h00, 1'b0, 8'hFF, 50);
    queue_idle(3);
    random_traffic(220);
    wait_idle();

    // The sender now idles often while the receiver rarely stalls.
    snd_idle_pct  = 79;
    rcv_stall_pct = 10;
    write_half(16'd0);
    random_traffic(140);
    wait_idle();
    write_half(16'd2);
    random_traffic(140);
    wait_idle();

    // Full rate on both sides.
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    write_half(16'd3);
    random_traffic(140);
    wait_idle();

    // Longest half period: a stop sequence holds its first phase through
    // all the ticks that follow.
    write_half(16'hFFFF);
    queue_lone(CMD_STOP, 40);
    wait_idle();

    if (error_count == 0) begin
      $display("i2c_master_bit_engine_tb: clean");
    end else begin
      $display("i2c_master_bit_engine_tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("i2c_master_bit_engine_tb: errors");
    $finish;
  end

endmodule
